// ===== sv/eca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Energy/charge accumulator package
// Shared constants, register indexes, display codes and the control struct
// that steps the saturating sums.
// ----------------------------------------------------------------------------
package eca_pkg;

    // Field widths of one sample, one result and a configuration write.
    localparam int BUS_W      = 15;
    localparam int CUR_W      = 16;
    localparam int PWR_W      = 20;
    localparam int MIN_W      = 17;
    localparam int OUT_SUM_W  = 48;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Configuration register widths.
    localparam int HOLD_W = 5;
    localparam int SAVE_W = 9;
    localparam int DISP_W = 7;

    // Default accumulator width.
    localparam int ACCUM_WIDTH_DEF = 48;

    // Reset values.
    localparam logic [HOLD_W-1:0] HOLD_COUNT_RST   = 5'd16;
    localparam logic [SAVE_W-1:0] SAVE_PERIOD_RST  = 9'd300;
    localparam logic [DISP_W-1:0] DISPLAY_STEP_RST = 7'd10;
    localparam logic [MIN_W-1:0]  MIN_RESET        = 17'd100000;

    // The hold counter never counts past this value.
    localparam logic [HOLD_W-1:0] HOLD_LIMIT = 5'd31;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_STEP = 2'd2;

    // Button display codes.
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_CLR   = 2'd1;
    localparam logic [1:0] BTN_OK    = 2'd2;
    localparam logic [1:0] BTN_BLANK = 2'd3;

    // Rotating display codes.
    localparam logic [2:0] ROT_NONE   = 3'd0;
    localparam logic [2:0] ROT_BUS    = 3'd1;
    localparam logic [2:0] ROT_POWER  = 3'd2;
    localparam logic [2:0] ROT_CHARGE = 3'd3;
    localparam logic [2:0] ROT_MIN    = 3'd4;
    localparam logic [2:0] ROT_BLANK  = 3'd5;

    // Control from the sample stage to the sum registers.
    typedef struct packed {
        logic step;   // one sample is processed this cycle
        logic clear;  // the sums are zeroed before this sample's addition
    } t_accum_ctl;

endpackage
`default_nettype wire

// ===== sv/eca_sat_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating energy and charge sums
// Holds the unsigned energy sum and the signed charge sum, applies a clear
// and adds one sample per step with saturation at the width limits.
// ----------------------------------------------------------------------------
module eca_sat_accum
    import eca_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire t_accum_ctl               i_ctl,
    input  wire        [PWR_W-1:0]        i_power_mw,
    input  wire signed [CUR_W-1:0]        i_current_ma,
    output logic       [ACCUM_WIDTH-1:0]  o_energy,
    output logic signed [ACCUM_WIDTH-1:0] o_charge
);

    logic        [ACCUM_WIDTH-1:0] r_energy, n_energy;
    logic signed [ACCUM_WIDTH-1:0] r_charge, n_charge;
    logic        [ACCUM_WIDTH:0]   e_sum;
    logic signed [ACCUM_WIDTH:0]   c_sum;

    // Sums as seen by the current sample, after any clear.
    assign o_energy = i_ctl.clear ? '0 : r_energy;
    assign o_charge = i_ctl.clear ? '0 : r_charge;

    assign e_sum = {1'b0, o_energy} + {{(ACCUM_WIDTH+1-PWR_W){1'b0}}, i_power_mw};
    assign c_sum = {o_charge[ACCUM_WIDTH-1], o_charge}
                 + {{(ACCUM_WIDTH+1-CUR_W){i_current_ma[CUR_W-1]}}, i_current_ma};

    always_comb begin
        n_energy = e_sum[ACCUM_WIDTH] ? '1 : e_sum[ACCUM_WIDTH-1:0];
        if (c_sum[ACCUM_WIDTH] != c_sum[ACCUM_WIDTH-1]) begin
            // Overflow: the sign of the wide sum tells which limit.
            n_charge = c_sum[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
        end else begin
            n_charge = c_sum[ACCUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= '0;
            r_charge <= '0;
        end else if (i_ctl.step) begin
            r_energy <= n_energy;
            r_charge <= n_charge;
        end
    end

`ifndef SYNTHESIS
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.step |=> $stable(r_energy) && $stable(r_charge))
        else $error("sums changed without a sample step");

    a_energy_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && i_ctl.clear
        |=> r_energy == {{(ACCUM_WIDTH-PWR_W){1'b0}}, $past(i_power_mw)})
        else $error("energy sum after clear is not the sample power");

    a_charge_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step && i_ctl.clear
        |=> r_charge == {{(ACCUM_WIDTH-CUR_W){$past(i_current_ma[CUR_W-1])}},
                         $past(i_current_ma)})
        else $error("charge sum after clear is not the sample current");
`endif

endmodule
`default_nettype wire

// ===== sv/energy_charge_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Energy and charge accumulator (coulomb counter)
// Takes one power-monitor sample per transfer, tracks the minimum bus
// voltage, handles the clear and save buttons, drives the save strobe and
// display codes, and keeps saturating energy and charge sums.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   sample    in         i_in_valid / o_in_ready       bus_mv, current_ma, power_mw,
//                                                      clear_pressed, save_pressed
//   result    out        o_out_valid / i_out_ready     save_now, button_display,
//                                                      rotate_display, energy_out,
//                                                      charge_out, min_out
//   config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// Flow: a sample transfer loads the input register, then one pass of adds and
// compares fills the output register when it is free or being emptied; one
// sample per cycle is sustained while the output is not stalled.
// Stalls: o_in_ready drops only while both registers hold data and the output
// is stalled. Reset (synchronous, active low) empties both registers, clears
// the sums and counters, sets the minimum to 100000 mV, loads the defaults.
// ----------------------------------------------------------------------------
module energy_charge_accumulator
    import eca_pkg::*;
#(
    parameter int ACCUM_WIDTH = ACCUM_WIDTH_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,

    input  wire                         i_cfg_we,
    input  wire        [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire        [CFG_DATA_W-1:0] i_cfg_data,

    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire        [BUS_W-1:0]      i_bus_mv,
    input  wire signed [CUR_W-1:0]      i_current_ma,
    input  wire        [PWR_W-1:0]      i_power_mw,
    input  wire                         i_clear_pressed,
    input  wire                         i_save_pressed,

    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic                        o_save_now,
    output logic       [1:0]            o_button_display,
    output logic       [2:0]            o_rotate_display,
    output logic       [OUT_SUM_W-1:0]  o_energy_out,
    output logic signed [OUT_SUM_W-1:0] o_charge_out,
    output logic       [MIN_W-1:0]      o_min_out
);

    // Configuration registers.
    logic [HOLD_W-1:0] r_hold_count;
    logic [SAVE_W-1:0] r_save_period;
    logic [DISP_W-1:0] r_display_step;

    // Input register.
    logic                    r_in_valid;
    logic [BUS_W-1:0]        r_bus;
    logic signed [CUR_W-1:0] r_cur;
    logic [PWR_W-1:0]        r_pwr;
    logic                    r_clr;
    logic                    r_sav;

    // Sample state.
    logic [MIN_W-1:0]  r_min,  n_min;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [SAVE_W-1:0] r_since, n_since;

    // Output register.
    logic                        r_out_valid;
    logic                        r_save_now,  n_save_now;
    logic [1:0]                  r_btn,       n_btn;
    logic [2:0]                  r_rot,       n_rot;
    logic [OUT_SUM_W-1:0]        r_energy_out, n_energy_out;
    logic signed [OUT_SUM_W-1:0] r_charge_out, n_charge_out;
    logic [MIN_W-1:0]            r_min_out;

    logic in_xfer;
    logic advance;
    logic clear_sums;
    logic [HOLD_W-1:0] hold_inc;
    logic [SAVE_W-1:0] s_eff;
    logic [SAVE_W-1:0] ds1, ds2, ds3, ds4;
    logic [MIN_W-1:0]  bus_ext;

    t_accum_ctl                    accum_ctl;
    logic       [ACCUM_WIDTH-1:0]  sum_energy;
    logic signed [ACCUM_WIDTH-1:0] sum_charge;

    // The work stage moves when it has a sample and the output register is
    // free or being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Configuration writes. Index values past the register list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count   <= HOLD_COUNT_RST;
            r_save_period  <= SAVE_PERIOD_RST;
            r_display_step <= DISPLAY_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HOLD_COUNT:   r_hold_count   <= i_cfg_data[HOLD_W-1:0];
                CFG_SAVE_PERIOD:  r_save_period  <= i_cfg_data[SAVE_W-1:0];
                CFG_DISPLAY_STEP: r_display_step <= i_cfg_data[DISP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bus <= i_bus_mv;
            r_cur <= i_current_ma;
            r_pwr <= i_power_mw;
            r_clr <= i_clear_pressed;
            r_sav <= i_save_pressed;
        end
    end

    // ------------------------------------------------------------------
    // Per-sample logic: minimum, clear button, save strobe and display.
    // ------------------------------------------------------------------
    assign bus_ext  = {{(MIN_W-BUS_W){1'b0}}, r_bus};
    assign hold_inc = r_hold + 1'b1;

    // Display step multiples; all fit in the nine-bit sample counter.
    assign ds1 = {{(SAVE_W-DISP_W){1'b0}}, r_display_step};
    assign ds2 = {ds1[SAVE_W-2:0], 1'b0};
    assign ds3 = ds2 + ds1;
    assign ds4 = {ds1[SAVE_W-3:0], 2'b00};

    always_comb begin
        n_btn      = BTN_NONE;
        n_hold     = r_hold;
        clear_sums = 1'b0;
        n_min      = (r_min > bus_ext) ? bus_ext : r_min;

        if (r_clr) begin
            // The counter advances up to one past the hold count and stops at
            // its limit; the actions fire only on the step that advances it.
            if (({1'b0, r_hold} < ({1'b0, r_hold_count} + 1'b1)) &&
                (r_hold != HOLD_LIMIT)) begin
                n_hold = hold_inc;
                if (hold_inc == HOLD_W'(1)) begin
                    n_btn = BTN_CLR;
                end
                if (hold_inc == r_hold_count) begin
                    n_btn      = BTN_OK;
                    clear_sums = 1'b1;
                    n_min      = bus_ext;
                end
            end
        end else begin
            if (r_hold != '0) begin
                n_btn = BTN_BLANK;
            end
            n_hold = '0;
        end

        // Save strobe restarts the sample count.
        n_save_now = 1'b0;
        s_eff      = r_since;
        if ((r_since == r_save_period) || r_sav) begin
            n_save_now = 1'b1;
            s_eff      = '0;
        end

        if (s_eff == '0) begin
            n_rot = ROT_BUS;
        end else if (s_eff == ds1) begin
            n_rot = ROT_POWER;
        end else if (s_eff == ds2) begin
            n_rot = ROT_CHARGE;
        end else if (s_eff == ds3) begin
            n_rot = ROT_MIN;
        end else if (s_eff == ds4) begin
            n_rot = ROT_BLANK;
        end else begin
            n_rot = ROT_NONE;
        end
        n_since = s_eff + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= MIN_RESET;
            r_hold  <= '0;
            r_since <= '0;
        end else if (advance) begin
            r_min   <= n_min;
            r_hold  <= n_hold;
            r_since <= n_since;
        end
    end

    // ------------------------------------------------------------------
    // Saturating sums. The outputs report the sums before this sample's
    // addition, after any clear.
    // ------------------------------------------------------------------
    assign accum_ctl.step  = advance;
    assign accum_ctl.clear = clear_sums;

    eca_sat_accum #(
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_sat_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (accum_ctl),
        .i_power_mw   (r_pwr),
        .i_current_ma (r_cur),
        .o_energy     (sum_energy),
        .o_charge     (sum_charge)
    );

    // Fit the accumulator width onto the fixed 48-bit result fields.
    generate
        if (ACCUM_WIDTH >= OUT_SUM_W) begin : g_sum_trunc
            assign n_energy_out = sum_energy[OUT_SUM_W-1:0];
            assign n_charge_out = sum_charge[OUT_SUM_W-1:0];
        end else begin : g_sum_ext
            assign n_energy_out = {{(OUT_SUM_W-ACCUM_WIDTH){1'b0}}, sum_energy};
            assign n_charge_out = {{(OUT_SUM_W-ACCUM_WIDTH){sum_charge[ACCUM_WIDTH-1]}},
                                   sum_charge};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_save_now   <= n_save_now;
            r_btn        <= n_btn;
            r_rot        <= n_rot;
            r_energy_out <= n_energy_out;
            r_charge_out <= n_charge_out;
            r_min_out    <= n_min;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_save_now       = r_save_now;
    assign o_button_display = r_btn;
    assign o_rotate_display = r_rot;
    assign o_energy_out     = r_energy_out;
    assign o_charge_out     = r_charge_out;
    assign o_min_out        = r_min_out;

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled while the output register is empty");

    a_save_shows_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_save_now |-> o_rotate_display == ROT_BUS)
        else $error("save strobe without the bus voltage display step");

    a_ok_clears_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_button_display == BTN_OK)
        |-> (o_energy_out == '0) && (o_charge_out == '0))
        else $error("clear acknowledged but sums not zero");

    a_min_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_min_out <= MIN_RESET)
        else $error("minimum voltage above its reset value");
`endif

endmodule
`default_nettype wire
